@@ sv/imm_pkg.sv @@
// Package with transfer types, widths and sequencer states for the interval merge cost block.
`default_nettype none

package imm_pkg;

  localparam int PIECE_W = 32;
  localparam int COST_W  = 48;

  typedef struct packed {
    logic [PIECE_W-1:0] piece_size;
    logic               last_piece;
  } in_t;

  typedef struct packed {
    logic [COST_W-1:0] min_cost;
    logic              overflow;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PSUM,
    ST_SPLIT,
    ST_DRAIN,
    ST_STORE
  } imm_state_t;

endpackage

`default_nettype wire

@@ sv/imm_ram.sv @@
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module imm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

@@ sv/interval_merge_min_cost.sv @@
// Top level: loads piece sizes, fills the interval cost table in RAM, emits the minimum merge cost.
//
//  channel   ports                      transfer when
//  input     start, busy, in_data       start && !busy
//  result    out_valid, out_data        out_valid (one cycle strobe)
//
//  Loading takes pieces back to back; busy stays low while loading.
//  The final piece starts the table fill: each interval of length L runs PSUM,
//  then one SPLIT step per split point, with one split read pair per cycle on the cost
//  RAM, then DRAIN and STORE; a single piece answers in the next cycle.
//  Synchronous active low reset returns to idle with an empty piece set.
//  The receiver cannot stall; the result strobe lasts exactly one cycle.
`default_nettype none

module interval_merge_min_cost #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire imm_pkg::in_t in_data,
  output logic             out_valid,
  output imm_pkg::out_t    out_data
);

  import imm_pkg::*;

  localparam int SIDE = MAX_ITEMS + 1;
  localparam int AW   = $clog2(SIDE);
  localparam int PW   = PIECE_W + $clog2(MAX_ITEMS);
  localparam int CW   = PW + $clog2(MAX_ITEMS);
  localparam int CAW  = $clog2(SIDE * SIDE);
  localparam int MW   = (CW > COST_W) ? CW : COST_W;

  imm_state_t state_r, state_nxt;

  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] n_r, n_nxt;
  logic [AW-1:0] len_r, len_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] mid_r, mid_nxt;
  logic [PW-1:0] sum_r, sum_nxt;
  logic [PW-1:0] span_r, span_nxt;
  logic          span_ld_r, span_ld_nxt;
  logic [CW-1:0] best_r, best_nxt;
  logic          first_r, first_nxt;
  logic          rd_v_r, rd_v_nxt;
  logic          rd_lz_r, rd_lz_nxt;
  logic          rd_rz_r, rd_rz_nxt;
  logic          lr_v_r, lr_v_nxt;
  logic [CW-1:0] lr_r, lr_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r, out_data_nxt;

  logic          in_xfer;
  logic          has_room;
  logic [AW-1:0] n_load;

  logic           ps_we;
  logic [AW-1:0]  ps_waddr;
  logic [PW-1:0]  ps_wdata;
  logic [PW-1:0]  ps_qa, ps_qb;

  logic           ct_we;
  logic [CAW-1:0] ct_waddr, ct_raddr_a, ct_raddr_b;
  logic [CW-1:0]  ct_qa, ct_qb;

  logic [CW-1:0]  cand;
  logic [MW-1:0]  best_w;
  logic [COST_W-1:0] best_sat;

  assign in_xfer  = start && !busy;
  assign has_room = (cnt_r < AW'(MAX_ITEMS));
  assign n_load   = has_room ? (cnt_r + AW'(1)) : cnt_r;

  assign ps_we    = in_xfer && has_room;
  assign ps_waddr = cnt_r + AW'(1);
  assign ps_wdata = sum_r + PW'(in_data.piece_size);

  assign ct_we      = (state_r == ST_STORE);
  assign ct_waddr   = CAW'(lo_r) * CAW'(SIDE) + CAW'(hi_r);
  assign ct_raddr_a = CAW'(lo_r) * CAW'(SIDE) + CAW'(mid_r);
  assign ct_raddr_b = CAW'(mid_r) * CAW'(SIDE) + CAW'(hi_r);

  assign cand     = lr_r + CW'(span_r);
  assign best_w   = MW'(best_r);
  assign best_sat = (best_w > MW'({COST_W{1'b1}})) ? {COST_W{1'b1}} : best_w[COST_W-1:0];

  imm_ram #(
    .WIDTH(PW),
    .DEPTH(SIDE)
  ) u_psum_ram (
    .clk    (clk),
    .we     (ps_we),
    .waddr  (ps_waddr),
    .wdata  (ps_wdata),
    .raddr_a(hi_r),
    .raddr_b(lo_r),
    .rdata_a(ps_qa),
    .rdata_b(ps_qb)
  );

  imm_ram #(
    .WIDTH(CW),
    .DEPTH(SIDE * SIDE)
  ) u_cost_ram (
    .clk    (clk),
    .we     (ct_we),
    .waddr  (ct_waddr),
    .wdata  (best_r),
    .raddr_a(ct_raddr_a),
    .raddr_b(ct_raddr_b),
    .rdata_a(ct_qa),
    .rdata_b(ct_qb)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    len_nxt       = len_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    sum_nxt       = sum_r;
    span_nxt      = span_r;
    span_ld_nxt   = span_ld_r;
    best_nxt      = best_r;
    first_nxt     = first_r;
    rd_v_nxt      = 1'b0;
    rd_lz_nxt     = rd_lz_r;
    rd_rz_nxt     = rd_rz_r;
    lr_v_nxt      = rd_v_r;
    lr_nxt        = (rd_lz_r ? '0 : ct_qa) + (rd_rz_r ? '0 : ct_qb);
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    busy          = (state_r != ST_IDLE);

    if (span_ld_r && state_r == ST_SPLIT) begin
      span_nxt    = ps_qa - ((lo_r == '0) ? '0 : ps_qb);
      span_ld_nxt = 1'b0;
    end

    if (lr_v_r && (first_r || cand < best_r)) begin
      best_nxt  = cand;
      first_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (has_room) begin
            cnt_nxt = cnt_r + AW'(1);
            sum_nxt = ps_wdata;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_piece) begin
            n_nxt = n_load;
            if (n_load == AW'(1)) begin
              out_valid_nxt         = 1'b1;
              out_data_nxt.min_cost = '0;
              out_data_nxt.overflow = ovf_r || !has_room;
              cnt_nxt               = '0;
              ovf_nxt               = 1'b0;
              sum_nxt               = '0;
            end else begin
              len_nxt     = AW'(2);
              lo_nxt      = '0;
              hi_nxt      = AW'(2);
              span_ld_nxt = 1'b1;
              state_nxt   = ST_PSUM;
            end
          end
        end
      end
      ST_PSUM: begin
        mid_nxt   = lo_r + AW'(1);
        first_nxt = 1'b1;
        state_nxt = ST_SPLIT;
      end
      ST_SPLIT: begin
        rd_v_nxt  = 1'b1;
        rd_lz_nxt = (mid_r == lo_r + AW'(1));
        rd_rz_nxt = (mid_r == hi_r - AW'(1));
        if (mid_r == hi_r - AW'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          mid_nxt = mid_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !lr_v_r) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        span_ld_nxt = 1'b1;
        state_nxt   = ST_PSUM;
        if (hi_r == n_r) begin
          if (len_r == n_r) begin
            out_valid_nxt         = 1'b1;
            out_data_nxt.min_cost = best_sat;
            out_data_nxt.overflow = ovf_r;
            cnt_nxt               = '0;
            ovf_nxt               = 1'b0;
            sum_nxt               = '0;
            span_ld_nxt           = 1'b0;
            state_nxt             = ST_IDLE;
          end else begin
            len_nxt = len_r + AW'(1);
            lo_nxt  = '0;
            hi_nxt  = len_r + AW'(1);
          end
        end else begin
          lo_nxt = lo_r + AW'(1);
          hi_nxt = hi_r + AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      sum_r       <= '0;
      span_ld_r   <= 1'b0;
      first_r     <= 1'b1;
      rd_v_r      <= 1'b0;
      lr_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      sum_r       <= sum_nxt;
      span_ld_r   <= span_ld_nxt;
      first_r     <= first_nxt;
      rd_v_r      <= rd_v_nxt;
      lr_v_r      <= lr_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    len_r      <= len_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    span_r     <= span_nxt;
    best_r     <= best_nxt;
    rd_lz_r    <= rd_lz_nxt;
    rd_rz_r    <= rd_rz_nxt;
    lr_r       <= lr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_single_piece: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.last_piece && n_load == AW'(1)) |=> out_valid)
    else $error("single piece set gave no result");

  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPLIT) |-> (mid_r > lo_r && mid_r < hi_r))
    else $error("split point outside interval");

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STORE) |-> (!rd_v_r && !lr_v_r && !first_r))
    else $error("cost written back before split pipeline drained");

  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STORE && hi_r == n_r && len_r == n_r) |=> (out_valid && !busy))
    else $error("full interval stored without result");

endmodule

`default_nettype wire

@@ verif/tb_interval_merge_min_cost.sv @@
`timescale 1ns / 100ps
// Testbench for interval_merge_min_cost: directed table and random piece sets vs given or merge-model costs.
module tb_interval_merge_min_cost;
  import imm_pkg::*;

  localparam int PIECES_MAX = 64;
  localparam int RANDOM_ITEMS = 700;
  localparam int NUM_ROWS = 25;
  localparam longint unsigned COST_INF = 64'd1 << 60;
  localparam logic [COST_W-1:0] COST_SAT = '1;

  typedef struct packed {
    logic [PIECE_W-1:0] size;
    logic               last;
    logic [7:0]         reps;
    logic               given;
    logic [COST_W-1:0]  cost;
    logic               ovf;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  int              held;
  bit              ovf_seen;
  longint unsigned psum [0:PIECES_MAX];
  longint unsigned span_cost [0:PIECES_MAX][0:PIECES_MAX];
  out_t            pending_costs [$];
  out_t            oldest;
  int              errors;
  bit              no_idle;
  dir_row_t        dir_tab [0:NUM_ROWS-1];

  interval_merge_min_cost #(
    .MAX_ITEMS(PIECES_MAX)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [COST_W-1:0] merge_cost(int n);
    int len, lo, mid;
    longint unsigned best, cand, span;
    if (n == 0) return '0;
    for (lo = 0; lo < n; lo++) span_cost[lo][lo+1] = 0;
    for (len = 2; len <= n; len++) begin
      for (lo = 0; lo + len <= n; lo++) begin
        span = psum[lo+len] - psum[lo];
        best = COST_INF;
        for (mid = lo + 1; mid < lo + len; mid++) begin
          cand = span_cost[lo][mid] + span_cost[mid][lo+len] + span;
          if (cand < best) best = cand;
        end
        span_cost[lo][lo+len] = best;
      end
    end
    best = span_cost[0][n];
    return (best > COST_SAT) ? COST_SAT : best[COST_W-1:0];
  endfunction

  function automatic void load_piece(in_t item, bit given, out_t given_res);
    out_t res;
    if (held < PIECES_MAX) begin
      psum[held+1] = psum[held] + item.piece_size;
      held++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (item.last_piece) begin
      res.min_cost = merge_cost(held);
      res.overflow = ovf_seen;
      pending_costs.push_back(given ? given_res : res);
      held = 0;
      ovf_seen = 1'b0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 200);
  endfunction

  function automatic logic [PIECE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    if (r < 7) return $urandom_range(0, 15);
    if (r == 7) return '1;
    if (r == 8) return '0;
    return 32'hFFFF_FFFF - $urandom_range(0, 255);
  endfunction

  task automatic send_piece(in_t item, bit given, out_t given_res);
    int gap;
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    load_piece(item, given, given_res);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_costs();
    start <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_costs.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_costs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual min_cost=%h overflow=%b",
                 $time, out_data.min_cost, out_data.overflow);
      end else begin
        oldest = pending_costs.pop_front();
        if (out_data.min_cost !== oldest.min_cost) begin
          errors++;
          $display("%0t: min_cost mismatch: expected %h actual %h",
                   $time, oldest.min_cost, out_data.min_cost);
        end
        if (out_data.overflow !== oldest.overflow) begin
          errors++;
          $display("%0t: overflow mismatch: expected %b actual %b",
                   $time, oldest.overflow, out_data.overflow);
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("tb_interval_merge_min_cost: FAIL");
    $finish;
  end

  initial begin
    int r, k, n, big_left, rand_sent;
    in_t item;
    out_t given_res;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    held     = 0;
    ovf_seen = 1'b0;
    psum[0]  = 0;
    errors   = 0;
    no_idle  = 1'b0;
    dir_tab = '{
      '{32'h0000_0000, 1'b1, 8'd1,  1'b1, 48'h0,              1'b0},
      '{32'hFFFF_FFFF, 1'b1, 8'd1,  1'b1, 48'h0,              1'b0},
      '{32'hFFFF_FFFF, 1'b0, 8'd1,  1'b0, 48'h0,              1'b0},
      '{32'hFFFF_FFFF, 1'b1, 8'd1,  1'b1, 48'h0001_FFFF_FFFE, 1'b0},
      '{32'h0000_0000, 1'b0, 8'd1,  1'b0, 48'h0,              1'b0},
      '{32'h0000_0000, 1'b1, 8'd1,  1'b1, 48'h0,              1'b0},
      '{32'h0000_0001, 1'b0, 8'd1,  1'b0, 48'h0,              1'b0},
      '{32'h0000_0002, 1'b0, 8'd1,  1'b0, 48'h0,              1'b0},
      '{32'h0000_0003, 1'b1, 8'd1,  1'b0, 48'h0,              1'b0},
      '{32'h0000_0005, 1'b0, 8'd1,  1'b0, 48'h0,              1'b0},
      '{32'h0000_0001, 1'b0, 8'd1,  1'b0, 48'h0,              1'b0},
      '{32'h0000_0001, 1'b0, 8'd1,  1'b0, 48'h0,              1'b0},
      '{32'h0000_0005, 1'b1, 8'd1,  1'b0, 48'h0,              1'b0},
      '{32'hAAAA_AAAA, 1'b0, 8'd1,  1'b0, 48'h0,              1'b0},
      '{32'h5555_5555, 1'b1, 8'd1,  1'b1, 48'h0000_FFFF_FFFF, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 8'd63, 1'b0, 48'h0,              1'b0},
      '{32'hFFFF_FFFF, 1'b1, 8'd1,  1'b1, 48'h017F_FFFF_FE80, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 8'd64, 1'b0, 48'h0,              1'b0},
      '{32'h0000_0000, 1'b0, 8'd1,  1'b0, 48'h0,              1'b0},
      '{32'h1234_5678, 1'b1, 8'd1,  1'b1, 48'h017F_FFFF_FE80, 1'b1},
      '{32'h0000_0007, 1'b1, 8'd1,  1'b1, 48'h0,              1'b0},
      '{32'h8000_0000, 1'b0, 8'd1,  1'b0, 48'h0,              1'b0},
      '{32'h0000_0001, 1'b0, 8'd1,  1'b0, 48'h0,              1'b0},
      '{32'h7FFF_FFFF, 1'b0, 8'd1,  1'b0, 48'h0,              1'b0},
      '{32'hDEAD_BEEF, 1'b1, 8'd1,  1'b0, 48'h0,              1'b0}
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < NUM_ROWS; r++) begin
      for (k = 0; k < dir_tab[r].reps; k++) begin
        item.piece_size = dir_tab[r].size;
        item.last_piece = dir_tab[r].last && (k == dir_tab[r].reps - 1);
        given_res.min_cost = dir_tab[r].cost;
        given_res.overflow = dir_tab[r].ovf;
        send_piece(item, dir_tab[r].given && item.last_piece, given_res);
      end
    end
    drain_costs();

    big_left  = 2;
    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55) n = $urandom_range(1, 6);
      else if (r < 85) n = $urandom_range(7, 14);
      else if (r < 97) n = $urandom_range(15, 30);
      else if (big_left > 0) begin
        big_left--;
        n = $urandom_range(60, 70);
      end else n = $urandom_range(2, 4);
      no_idle = ($urandom_range(0, 5) == 0);
      for (k = 0; k < n; k++) begin
        item.piece_size = pick_size();
        item.last_piece = (k == n - 1);
        send_piece(item, 1'b0, '0);
      end
      rand_sent += n;
      if ($urandom_range(0, 9) == 0) drain_costs();
    end

    drain_costs();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb_interval_merge_min_cost: PASS");
    end else begin
      $display("tb_interval_merge_min_cost: FAIL");
    end
    $finish;
  end

endmodule
